FILE: rtl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants of the semi-sorted cuckoo filter engine.
// ----------------------------------------------------------------------------
package cfs_pkg;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_CONTAIN  = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BUCKET_LOG2 = 2'd0,
    CFG_TAG_BITS    = 2'd1,
    CFG_RSVD2       = 2'd2,
    CFG_RSVD3       = 2'd3
  } cfg_idx_e;

  localparam int unsigned SlotsPerBucket = 4;
  localparam int unsigned NibbleBits     = 4;
  localparam int unsigned CodeBits       = SlotsPerBucket * NibbleBits;
  localparam int unsigned CountBits      = 13;
  localparam logic [CountBits-1:0] CountMax = 13'h1fff;
  localparam logic [31:0] AltMult        = 32'h5bd1e995;
  localparam logic [15:0] LfsrSeed       = 16'hace1;
  localparam logic [3:0]  BucketLog2Rst  = 4'd10;
  localparam logic [4:0]  TagBitsRst     = 5'd16;
  localparam logic [4:0]  TagBitsMin     = 5'd5;

endpackage

FILE: rtl/cfs_if.sv
// ----------------------------------------------------------------------------
// cfs_if
// Valid/ready channels of the cuckoo filter engine.
// ----------------------------------------------------------------------------
interface cfs_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] hash_value;
  modport source (output valid, output cmd, output hash_value, input ready);
  modport sink   (input valid, input cmd, input hash_value, output ready);
endinterface

interface cfs_result_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [1:0]  status;
  logic [12:0] item_count;
  modport source (output valid, output success, output status, output item_count,
                  input ready);
  modport sink   (input valid, input success, input status, input item_count,
                  output ready);
endinterface

interface cfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [7:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cfs_alt_hash.sv
// ----------------------------------------------------------------------------
// cfs_alt_hash
// Alternate bucket index: index XOR low bits of (tag times the mix constant), masked.
// ----------------------------------------------------------------------------
module cfs_alt_hash #(
  parameter int unsigned IW = 10,
  parameter int unsigned TW = 16
) (
  input  logic [IW-1:0] idx_i,
  input  logic [TW-1:0] tag_i,
  input  logic [IW-1:0] mask_i,
  output logic [IW-1:0] alt_o
);
  import cfs_pkg::*;

  logic [31:0] prod;

  always_comb begin
    prod  = 32'(tag_i) * AltMult;
    alt_o = (idx_i ^ prod[IW-1:0]) & mask_i;
  end

endmodule

FILE: rtl/cfs_slot_sort.sv
// ----------------------------------------------------------------------------
// cfs_slot_sort
// Orders four tags by low nibble and packs them into a bucket word.
// ----------------------------------------------------------------------------
module cfs_slot_sort #(
  parameter int unsigned TW = 16,
  parameter int unsigned WW = 16 + 4 * (TW - 4)
) (
  input  logic [TW-1:0] tags_i [4],
  output logic [WW-1:0] word_o
);
  import cfs_pkg::*;

  localparam int unsigned HW = TW - NibbleBits;

  logic [TW-1:0] s [4];
  logic [TW-1:0] tmp;

  // Fixed five-stage network; swaps only on strictly greater nibbles.
  always_comb begin
    tmp = '0;
    s   = tags_i;
    if (s[0][3:0] > s[2][3:0]) begin tmp = s[0]; s[0] = s[2]; s[2] = tmp; end
    if (s[1][3:0] > s[3][3:0]) begin tmp = s[1]; s[1] = s[3]; s[3] = tmp; end
    if (s[0][3:0] > s[1][3:0]) begin tmp = s[0]; s[0] = s[1]; s[1] = tmp; end
    if (s[2][3:0] > s[3][3:0]) begin tmp = s[2]; s[2] = s[3]; s[3] = tmp; end
    if (s[1][3:0] > s[2][3:0]) begin tmp = s[1]; s[1] = s[2]; s[2] = tmp; end
    for (int k = 0; k < 4; k++) begin
      word_o[NibbleBits*k +: NibbleBits] = s[k][3:0];
      word_o[CodeBits + HW*k +: HW]      = s[k][TW-1:NibbleBits];
    end
  end

endmodule

FILE: rtl/cuckoo_filter_semisorted.sv
// ----------------------------------------------------------------------------
// cuckoo_filter_semisorted
// Cuckoo filter engine with four-slot buckets kept sorted by low nibble.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                              Handshake
// cfg_i    in   index, data                          valid/ready, always ready
// in_i     in   cmd, hash_value                      valid/ready
// out_o    out  success, status, item_count          valid/ready
//
// One word is processed at a time through a small sequencer around one bucket
// memory port and one shared alternate-index hash unit.
// Contain checks the parked victim, then the first bucket and, if needed, the
// alternate one; delete searches the buckets likewise, plus any re-add of the
// parked tag; add fails at once when the victim store is full, otherwise it
// runs kick rounds. Reset sweeps the bucket memory, one bucket a cycle, and
// clear runs the same sweep; no word is accepted during the sweep.
// A finished result waits in the output register until taken, which holds the
// engine once its next result is due; the input is ready as the result loads.
// ----------------------------------------------------------------------------
module cuckoo_filter_semisorted #(
  parameter int unsigned N_BUCKETS    = 1024,
  parameter int unsigned MAX_TAG_BITS = 16,
  parameter int unsigned MAX_KICKS    = 500
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfs_cfg_if.sink    cfg_i,
  cfs_item_if.sink   in_i,
  cfs_result_if.source out_o
);
  import cfs_pkg::*;

  localparam int unsigned IW  = (N_BUCKETS > 1) ? $clog2(N_BUCKETS) : 1;
  localparam int unsigned CAP = $clog2(N_BUCKETS + 1) - 1;
  localparam int unsigned TW  = MAX_TAG_BITS;
  localparam int unsigned HW  = TW - NibbleBits;
  localparam int unsigned WW  = CodeBits + SlotsPerBucket * HW;
  localparam int unsigned RW  = $clog2(MAX_KICKS + 1);
  localparam logic [IW-1:0] LastAddr  = IW'(N_BUCKETS - 1);
  localparam logic [RW-1:0] LastRound = RW'(MAX_KICKS - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ALT  = 4'd2;
  localparam logic [3:0] S_PRD  = 4'd3;
  localparam logic [3:0] S_PEV  = 4'd4;
  localparam logic [3:0] S_PALT = 4'd5;
  localparam logic [3:0] S_CRD1 = 4'd6;
  localparam logic [3:0] S_C1   = 4'd7;
  localparam logic [3:0] S_CRD2 = 4'd8;
  localparam logic [3:0] S_C2   = 4'd9;
  localparam logic [3:0] S_DRD1 = 4'd10;
  localparam logic [3:0] S_D1   = 4'd11;
  localparam logic [3:0] S_DRD2 = 4'd12;
  localparam logic [3:0] S_D2   = 4'd13;
  localparam logic [3:0] S_RESP = 4'd14;

  logic [3:0]            state_q, state_d;
  logic [3:0]            bcl_q;
  logic [4:0]            tb_q;
  logic [1:0]            cmd_q;
  logic [TW-1:0]         tag_q, ctag_q, vtag_q;
  logic [IW-1:0]         i1_q, i2_q, cur_q, addr_q, vidx_q;
  logic                  vvalid_q, vmatch_q, clr_resp_q;
  logic [RW-1:0]         round_q;
  logic [CountBits-1:0]  cnt_q;
  logic [15:0]           lfsr_q;
  logic                  res_ok_q;
  logic [1:0]            res_st_q;
  logic                  out_valid_q, out_succ_q;
  logic [1:0]            out_st_q;
  logic [CountBits-1:0]  out_cnt_q;
  logic [WW-1:0]         mem_q [N_BUCKETS];
  logic [WW-1:0]         rdata_q;

  logic [5:0]            tb_eff;
  logic [4:0]            n_eff;
  logic [IW-1:0]         imask;
  logic [TW-1:0]         tmask;
  logic [HW-1:0]         hmask;
  logic [TW-1:0]         new_tag;
  logic [IW-1:0]         alt_idx_in, alt_res;
  logic [TW-1:0]         alt_tag_in;
  logic [TW-1:0]         rd_tag [4];
  logic [TW-1:0]         wr_tag [4];
  logic [WW-1:0]         sorted_word, mem_wdata;
  logic                  mem_we;
  logic                  fe_found, mt_found;
  logic [1:0]            fe_idx, mt_idx;
  logic [15:0]           lfsr_nx;
  logic                  vmatch_now;
  logic                  add_full;
  logic                  in_acc;
  logic                  out_free;
  logic [CountBits-1:0]  total;

  // Effective register values.
  always_comb begin
    tb_eff = {1'b0, tb_q};
    if (tb_q < TagBitsMin) tb_eff = {1'b0, TagBitsMin};
    if (tb_eff > 6'(TW)) tb_eff = 6'(TW);
    n_eff = ({1'b0, bcl_q} < 5'(CAP)) ? {1'b0, bcl_q} : 5'(CAP);
    for (int i = 0; i < IW; i++) imask[i] = (5'(i) < n_eff);
    for (int i = 0; i < TW; i++) tmask[i] = (6'(i) < tb_eff);
    for (int i = 0; i < HW; i++) hmask[i] = (6'(i) < (tb_eff - 6'd4));
    new_tag = in_i.hash_value[TW-1:0] & tmask;
    if (new_tag == '0) new_tag = TW'(1);
  end

  assign alt_idx_in = (state_q == S_ALT) ? i1_q  : cur_q;
  assign alt_tag_in = (state_q == S_ALT) ? tag_q : ctag_q;

  cfs_alt_hash #(.IW(IW), .TW(TW)) u_alt (
    .idx_i  (alt_idx_in),
    .tag_i  (alt_tag_in),
    .mask_i (imask),
    .alt_o  (alt_res)
  );

  assign vmatch_now = vvalid_q && (vtag_q == tag_q) && (vidx_q == i1_q || vidx_q == alt_res);
  assign add_full   = (cmd_e'(cmd_q) == CMD_ADD) && vvalid_q;

  // Bucket decode and slot searches.
  always_comb begin
    fe_found = 1'b0;
    fe_idx   = 2'd0;
    mt_found = 1'b0;
    mt_idx   = 2'd0;
    for (int k = 0; k < 4; k++) begin
      rd_tag[k] = {rdata_q[CodeBits + HW*k +: HW] & hmask, rdata_q[NibbleBits*k +: NibbleBits]};
    end
    for (int k = 3; k >= 0; k--) begin
      if (rd_tag[k] == '0) begin fe_found = 1'b1; fe_idx = 2'(k); end
      if (rd_tag[k] == tag_q) begin mt_found = 1'b1; mt_idx = 2'(k); end
    end
    lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  end

  always_comb begin
    wr_tag = rd_tag;
    mem_we = 1'b0;
    unique case (state_q)
      S_CLR: mem_we = 1'b1;
      S_PEV: begin
        if (fe_found) begin
          wr_tag[fe_idx] = ctag_q;
          mem_we = 1'b1;
        end else if (round_q != '0) begin
          wr_tag[lfsr_nx[1:0]] = ctag_q;
          mem_we = 1'b1;
        end
      end
      S_D1, S_D2: begin
        wr_tag[mt_idx] = '0;
        mem_we = mt_found;
      end
      default: ;
    endcase
  end

  cfs_slot_sort #(.TW(TW), .WW(WW)) u_sort (
    .tags_i (wr_tag),
    .word_o (sorted_word)
  );

  assign mem_wdata = (state_q == S_CLR) ? '0 : sorted_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_q];
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (addr_q == LastAddr) state_d = clr_resp_q ? S_RESP : S_IDLE;
      S_IDLE: if (in_acc) state_d = S_ALT;
      S_ALT: begin
        unique case (cmd_e'(cmd_q))
          CMD_ADD:     state_d = vvalid_q ? S_RESP : S_PRD;
          CMD_CONTAIN: state_d = vmatch_now ? S_RESP : S_CRD1;
          CMD_DELETE:  state_d = S_DRD1;
          CMD_CLEAR:   state_d = S_CLR;
        endcase
      end
      S_PRD:  state_d = S_PEV;
      S_PEV:  state_d = fe_found ? S_RESP : S_PALT;
      S_PALT: state_d = (round_q == LastRound) ? S_RESP : S_PRD;
      S_CRD1: state_d = S_C1;
      S_C1:   state_d = mt_found ? S_RESP : S_CRD2;
      S_CRD2: state_d = S_C2;
      S_C2:   state_d = S_RESP;
      S_DRD1: state_d = S_D1;
      S_D1:   state_d = mt_found ? (vvalid_q ? S_PRD : S_RESP) : S_DRD2;
      S_DRD2: state_d = S_D2;
      S_D2:   state_d = (mt_found && vvalid_q) ? S_PRD : S_RESP;
      S_RESP: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    total = cnt_q;
    if (vvalid_q && cnt_q != CountMax) total = cnt_q + CountBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      addr_q      <= '0;
      clr_resp_q  <= 1'b0;
      bcl_q       <= BucketLog2Rst;
      tb_q        <= TagBitsRst;
      cmd_q       <= '0;
      tag_q       <= '0;
      ctag_q      <= '0;
      i1_q        <= '0;
      i2_q        <= '0;
      cur_q       <= '0;
      vmatch_q    <= 1'b0;
      cnt_q       <= '0;
      vvalid_q    <= 1'b0;
      vidx_q      <= '0;
      vtag_q      <= '0;
      lfsr_q      <= LfsrSeed;
      round_q     <= '0;
      res_ok_q    <= 1'b0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_succ_q  <= 1'b0;
      out_st_q    <= ST_OK;
      out_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_idx_e'(cfg_i.index))
          CFG_BUCKET_LOG2: bcl_q <= cfg_i.data[3:0];
          CFG_TAG_BITS:    tb_q  <= cfg_i.data[4:0];
          default: ;
        endcase
      end
      if (state_q == S_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          if (addr_q != LastAddr) addr_q <= addr_q + IW'(1);
          res_ok_q <= 1'b1;
          res_st_q <= ST_OK;
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd_q <= in_i.cmd;
            tag_q <= new_tag;
            i1_q  <= in_i.hash_value[32 +: IW] & imask;
          end
        end
        S_ALT: begin
          i2_q     <= alt_res;
          vmatch_q <= vmatch_now;
          res_ok_q <= !add_full;
          res_st_q <= add_full ? ST_FULL : ST_OK;
          cur_q    <= i1_q;
          ctag_q   <= tag_q;
          round_q  <= '0;
          if (cmd_e'(cmd_q) == CMD_CLEAR) begin
            addr_q     <= '0;
            clr_resp_q <= 1'b1;
            cnt_q      <= '0;
            vvalid_q   <= 1'b0;
            vidx_q     <= '0;
            vtag_q     <= '0;
          end else begin
            addr_q <= i1_q;
          end
        end
        S_PEV: begin
          if (fe_found) begin
            if (cnt_q != CountMax) cnt_q <= cnt_q + CountBits'(1);
          end else if (round_q != '0) begin
            lfsr_q <= lfsr_nx;
            ctag_q <= rd_tag[lfsr_nx[1:0]];
          end
        end
        S_PALT: begin
          cur_q   <= alt_res;
          addr_q  <= alt_res;
          round_q <= round_q + RW'(1);
          if (round_q == LastRound) begin
            vvalid_q <= 1'b1;
            vidx_q   <= alt_res & LastAddr;
            vtag_q   <= ctag_q;
          end
        end
        S_C1: addr_q <= i2_q;
        S_C2: begin
          if (!mt_found) begin
            res_ok_q <= 1'b0;
            res_st_q <= ST_NOT_FOUND;
          end
        end
        S_D1, S_D2: begin
          if (mt_found) begin
            if (cnt_q != '0) cnt_q <= cnt_q - CountBits'(1);
            if (vvalid_q) begin
              // The parked tag gets another chance now that a slot is free.
              vvalid_q <= 1'b0;
              cur_q    <= vidx_q & imask;
              addr_q   <= vidx_q & imask;
              ctag_q   <= vtag_q;
              round_q  <= '0;
            end
          end else if (state_q == S_D1) begin
            addr_q <= i2_q;
          end else if (vmatch_q) begin
            vvalid_q <= 1'b0;
          end else begin
            res_ok_q <= 1'b0;
            res_st_q <= ST_NOT_FOUND;
          end
        end
        S_RESP: begin
          clr_resp_q <= 1'b0;
          if (out_free) begin
            out_succ_q  <= res_ok_q;
            out_st_q    <= res_st_q;
            out_cnt_q   <= total;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.success    = out_succ_q;
  assign out_o.status     = out_st_q;
  assign out_o.item_count = out_cnt_q;

endmodule
